[rtl/core/lfti_pkg.sv]
package lfti_pkg;

    localparam int TAB_LEN = 20;
    localparam int IDX_W   = 5;
    localparam int VAL_W   = 27;
    localparam int Q_W     = 27;
    localparam int NUM_W   = 2 * VAL_W;

    localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(TAB_LEN - 1);

    localparam logic FUNC_LENS_TO_FOV = 1'b0;
    localparam logic FUNC_FOV_TO_LENS = 1'b1;

    typedef struct packed {
        logic             func;
        logic [VAL_W-1:0] x;
        logic [IDX_W-1:0] idx;
    } seg_t;

    typedef struct packed {
        logic             func;
        logic [VAL_W-1:0] dxo;
        logic [VAL_W-1:0] dy;
        logic [VAL_W-1:0] den;
        logic [VAL_W-1:0] y0;
    } opnd_t;

    typedef struct packed {
        logic             func;
        logic [NUM_W-1:0] num;
        logic [VAL_W-1:0] den;
        logic [VAL_W-1:0] y0;
    } div_in_t;

    typedef struct packed {
        logic             func;
        logic [NUM_W-1:0] rem;
        logic [VAL_W-1:0] den;
        logic [VAL_W-1:0] y0;
        logic [Q_W-1:0]   q;
    } div_st_t;

    function automatic logic [VAL_W-1:0] lens_rom(input logic [IDX_W-1:0] i);
        logic [VAL_W-1:0] v;
        unique case (i)
            5'd0:    v = 27'd10094;
            5'd1:    v = 27'd11040;
            5'd2:    v = 27'd15360;
            5'd3:    v = 27'd17408;
            5'd4:    v = 27'd24576;
            5'd5:    v = 27'd35840;
            5'd6:    v = 27'd51200;
            5'd7:    v = 27'd87040;
            5'd8:    v = 27'd102400;
            5'd9:    v = 27'd138240;
            5'd10:   v = 27'd204800;
            5'd11:   v = 27'd512000;
            5'd12:   v = 27'd640000;
            5'd13:   v = 27'd819200;
            5'd14:   v = 27'd1024000;
            5'd15:   v = 27'd2560000;
            5'd16:   v = 27'd5120000;
            5'd17:   v = 27'd25600000;
            5'd18:   v = 27'd51200000;
            5'd19:   v = 27'd102400000;
            default: v = 27'd102400000;
        endcase
        return v;
    endfunction

    function automatic logic [VAL_W-1:0] fov_rom(input logic [IDX_W-1:0] i);
        logic [VAL_W-1:0] v;
        unique case (i)
            5'd0:    v = 27'd11468800;
            5'd1:    v = 27'd10485760;
            5'd2:    v = 27'd7536640;
            5'd3:    v = 27'd6684672;
            5'd4:    v = 27'd5505024;
            5'd5:    v = 27'd4128768;
            5'd6:    v = 27'd3014656;
            5'd7:    v = 27'd1835008;
            5'd8:    v = 27'd1572864;
            5'd9:    v = 27'd1179648;
            5'd10:   v = 27'd786432;
            5'd11:   v = 27'd327680;
            5'd12:   v = 27'd262144;
            5'd13:   v = 27'd204800;
            5'd14:   v = 27'd163840;
            5'd15:   v = 27'd65536;
            5'd16:   v = 27'd32768;
            5'd17:   v = 27'd6554;
            5'd18:   v = 27'd3277;
            5'd19:   v = 27'd1638;
            default: v = 27'd1638;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/lfti_seg.sv]
module lfti_seg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_func,
    input  logic [lfti_pkg::VAL_W-1:0] in_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output lfti_pkg::seg_t        out_data
);
    import lfti_pkg::*;

    logic vld_reg;
    seg_t seg_reg;
    seg_t seg_next;
    logic adv;

    assign adv      = !vld_reg || out_ready;
    assign in_ready = adv;

    always_comb
    begin
        logic [VAL_W-1:0] x;
        logic [IDX_W-1:0] idx;
        x   = in_value;
        idx = IDX_LAST;
        if (in_func == FUNC_LENS_TO_FOV)
        begin
            if (in_value < lens_rom(IDX_W'(0)))
                x = lens_rom(IDX_W'(0));
            else if (in_value > lens_rom(IDX_LAST))
                x = lens_rom(IDX_LAST);
            for (int i = TAB_LEN - 1; i >= 0; i--)
                if (x < lens_rom(IDX_W'(i)))
                    idx = IDX_W'(i);
        end
        else
        begin
            if (in_value < fov_rom(IDX_LAST))
                x = fov_rom(IDX_LAST);
            else if (in_value > fov_rom(IDX_W'(0)))
                x = fov_rom(IDX_W'(0));
            for (int i = TAB_LEN - 1; i >= 0; i--)
                if (x > fov_rom(IDX_W'(i)))
                    idx = IDX_W'(i);
        end
        if (idx < IDX_FIRST)
            idx = IDX_FIRST;
        seg_next.func = in_func;
        seg_next.x    = x;
        seg_next.idx  = idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (adv)
            vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            seg_reg <= seg_next;
    end

    assign out_valid = vld_reg;
    assign out_data  = seg_reg;

endmodule

[rtl/core/lfti_mul.sv]
module lfti_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lfti_pkg::seg_t    in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output lfti_pkg::div_in_t out_data
);
    import lfti_pkg::*;

    logic    opv_reg;
    opnd_t   op_reg;
    opnd_t   op_next;
    logic    mv_reg;
    div_in_t m_reg;
    div_in_t m_next;
    logic    adv_op;
    logic    adv_m;

    assign adv_m    = !mv_reg || out_ready;
    assign adv_op   = !opv_reg || adv_m;
    assign in_ready = adv_op;

    always_comb
    begin
        logic [IDX_W-1:0] ip;
        logic [VAL_W-1:0] l0;
        logic [VAL_W-1:0] l1;
        logic [VAL_W-1:0] f0;
        logic [VAL_W-1:0] f1;
        ip = in_data.idx - IDX_W'(1);
        l0 = lens_rom(ip);
        l1 = lens_rom(in_data.idx);
        f0 = fov_rom(ip);
        f1 = fov_rom(in_data.idx);
        op_next.func = in_data.func;
        if (in_data.func == FUNC_LENS_TO_FOV)
        begin
            op_next.dxo = in_data.x - l0;
            op_next.dy  = f0 - f1;
            op_next.den = l1 - l0;
            op_next.y0  = f0;
        end
        else
        begin
            op_next.dxo = f0 - in_data.x;
            op_next.dy  = l1 - l0;
            op_next.den = f0 - f1;
            op_next.y0  = l0;
        end
    end

    always_comb
    begin
        m_next.func = op_reg.func;
        m_next.num  = NUM_W'(op_reg.dxo) * NUM_W'(op_reg.dy);
        m_next.den  = op_reg.den;
        m_next.y0   = op_reg.y0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opv_reg <= 1'b0;
            mv_reg  <= 1'b0;
        end
        else
        begin
            if (adv_op)
                opv_reg <= in_valid;
            if (adv_m)
                mv_reg <= opv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_op)
            op_reg <= op_next;
        if (adv_m)
            m_reg <= m_next;
    end

    assign out_valid = mv_reg;
    assign out_data  = m_reg;

endmodule

[rtl/core/lfti_div.sv]
module lfti_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lfti_pkg::div_in_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output lfti_pkg::div_st_t out_data
);
    import lfti_pkg::*;

    localparam int NS = Q_W;

    div_st_t        st_reg  [NS];
    div_st_t        st_next [NS];
    div_st_t        src     [NS];
    logic [NS-1:0]  vld_reg;
    logic [NS-1:0]  pv;
    logic [NS:0]    adv;

    assign adv[NS] = out_ready;

    genvar j;
    generate
        for (j = 0; j < NS; j++)
        begin : g_stage
            localparam int K = NS - 1 - j;
            logic [NUM_W-1:0] sh;

            if (j == 0)
            begin : g_first
                assign src[j] = '{func: in_data.func, rem: in_data.num, den: in_data.den,
                                  y0: in_data.y0, q: '0};
                assign pv[j]  = in_valid;
            end
            else
            begin : g_rest
                assign src[j] = st_reg[j-1];
                assign pv[j]  = vld_reg[j-1];
            end

            assign adv[j] = !vld_reg[j] || adv[j+1];
            assign sh     = NUM_W'(src[j].den) << K;

            always_comb
            begin
                st_next[j] = src[j];
                if (src[j].rem >= sh)
                begin
                    st_next[j].rem  = src[j].rem - sh;
                    st_next[j].q[K] = 1'b1;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[j] <= 1'b0;
                else if (adv[j])
                    vld_reg[j] <= pv[j];
            end

            always_ff @(posedge clk)
            begin
                if (adv[j])
                    st_reg[j] <= st_next[j];
            end
        end
    endgenerate

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NS-1];
    assign out_data  = st_reg[NS-1];

endmodule

[rtl/core/lens_fov_table_interpolator.sv]
// Channel | Handshake                   | Payload
// item    | item_valid / item_ready     | func, value
// result  | result_valid / result_ready | converted
//
// There are 31 register stages: segment search, operand fetch, multiply,
// 27 restoring divide stages (one quotient bit each), final add and clip.
// One transaction is accepted per cycle unless a result stall has filled the
// pipeline; every stage has its own valid bit and fills bubbles while the
// result side stalls.
// Reset clears all valid bits; payload registers are not reset.
module lens_fov_table_interpolator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  logic                       func,
    input  logic [lfti_pkg::VAL_W-1:0] value,
    output logic                       result_valid,
    input  logic                       result_ready,
    output logic [lfti_pkg::VAL_W-1:0] converted
);
    import lfti_pkg::*;

    logic    seg_valid;
    logic    seg_ready;
    seg_t    seg_data;
    logic    mul_valid;
    logic    mul_ready;
    div_in_t mul_data;
    logic    div_valid;
    logic    div_ready;
    div_st_t div_data;

    logic             vld_reg;
    logic [VAL_W-1:0] y_reg;
    logic [VAL_W-1:0] y_next;

    lfti_seg u_seg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_valid),
        .in_ready  (item_ready),
        .in_func   (func),
        .in_value  (value),
        .out_valid (seg_valid),
        .out_ready (seg_ready),
        .out_data  (seg_data)
    );

    lfti_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (seg_valid),
        .in_ready  (seg_ready),
        .in_data   (seg_data),
        .out_valid (mul_valid),
        .out_ready (mul_ready),
        .out_data  (mul_data)
    );

    lfti_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_valid),
        .in_ready  (mul_ready),
        .in_data   (mul_data),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    assign div_ready = !vld_reg || result_ready;

    always_comb
    begin
        logic [VAL_W:0] sum;
        if (div_data.func == FUNC_LENS_TO_FOV)
            sum = {1'b0, div_data.y0} - (VAL_W+1)'(div_data.q);
        else
            sum = {1'b0, div_data.y0} + (VAL_W+1)'(div_data.q);
        if (sum[VAL_W])
            y_next = (div_data.func == FUNC_LENS_TO_FOV) ? '0 : '1;
        else
            y_next = sum[VAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (div_ready)
            vld_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (div_ready)
            y_reg <= y_next;
    end

    assign result_valid = vld_reg;
    assign converted    = y_reg;

endmodule

[verif/lens_fov_table_interpolator_tb.sv]
module lens_fov_table_interpolator_tb;
    import lfti_pkg::*;

    localparam longint LENS_PTS [TAB_LEN] = '{
        10094, 11040, 15360, 17408, 24576, 35840, 51200, 87040,
        102400, 138240, 204800, 512000, 640000, 819200, 1024000,
        2560000, 5120000, 25600000, 51200000, 102400000
    };
    localparam longint FOV_PTS [TAB_LEN] = '{
        11468800, 10485760, 7536640, 6684672, 5505024, 4128768, 3014656,
        1835008, 1572864, 1179648, 786432, 327680, 262144, 204800, 163840,
        65536, 32768, 6554, 3277, 1638
    };
    localparam longint FIELD_MAX = (longint'(1) << VAL_W) - 1;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_PER_PHASE = 160;

    class conversion_scoreboard;
        longint pending_conversions[$];
        int     mismatches;
        int     checked;

        function void note_item(longint expected);
            pending_conversions.push_back(expected);
        endfunction

        function void check_result(logic [VAL_W-1:0] got);
            longint expected;
            if (pending_conversions.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: converted=%0d", got);
                return;
            end
            expected = pending_conversions.pop_front();
            checked++;
            if (longint'(got) != expected)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch on result %0d: converted expected %0d got %0d",
                             checked, expected, got);
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_ready;
    logic             func;
    logic [VAL_W-1:0] value;
    logic             result_valid;
    logic             result_ready;
    logic [VAL_W-1:0] converted;

    conversion_scoreboard sb;
    int idle_pct;
    int stall_pct;
    int quiet_cycles;
    int sent;

    lens_fov_table_interpolator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .func         (func),
        .value        (value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .converted    (converted)
    );

    always #2 clk = ~clk;

    function automatic longint predict_conversion(logic f, logic [VAL_W-1:0] v);
        longint x;
        longint xa;
        longint xb;
        longint ya;
        longint yb;
        longint y;
        int     i;
        x = longint'(v);
        i = 0;
        if (f == FUNC_LENS_TO_FOV)
        begin
            if (x < LENS_PTS[0])
                x = LENS_PTS[0];
            else if (x > LENS_PTS[TAB_LEN-1])
                x = LENS_PTS[TAB_LEN-1];
            while (i < TAB_LEN && !(x < LENS_PTS[i]))
                i++;
        end
        else
        begin
            if (x < FOV_PTS[TAB_LEN-1])
                x = FOV_PTS[TAB_LEN-1];
            else if (x > FOV_PTS[0])
                x = FOV_PTS[0];
            while (i < TAB_LEN && !(x > FOV_PTS[i]))
                i++;
        end
        if (i >= TAB_LEN)
            i = TAB_LEN - 1;
        else if (i == 0)
            i = 1;
        if (f == FUNC_LENS_TO_FOV)
        begin
            xa = LENS_PTS[i-1]; xb = LENS_PTS[i]; ya = FOV_PTS[i-1]; yb = FOV_PTS[i];
        end
        else
        begin
            xa = FOV_PTS[i-1]; xb = FOV_PTS[i]; ya = LENS_PTS[i-1]; yb = LENS_PTS[i];
        end
        y = ya + ((x - xa) * (yb - ya)) / (xb - xa);
        if (y < 0)
            y = 0;
        else if (y > FIELD_MAX)
            y = FIELD_MAX;
        return y;
    endfunction

    task automatic send_item(logic f, logic [VAL_W-1:0] v);
        if ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        item_valid <= 1'b1;
        func       <= f;
        value      <= v;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        sb.note_item(predict_conversion(f, v));
        sent++;
    endtask

    task automatic send_random_item();
        logic             f;
        int               k;
        logic [VAL_W-1:0] v;
        f = 1'($urandom_range(1));
        if ($urandom_range(3) == 0)
            v = VAL_W'($urandom);
        else
        begin
            k = $urandom_range(TAB_LEN - 1, 1);
            if (f == FUNC_LENS_TO_FOV)
                v = VAL_W'($urandom_range(int'(LENS_PTS[k]), int'(LENS_PTS[k-1])));
            else
                v = VAL_W'($urandom_range(int'(FOV_PTS[k-1]), int'(FOV_PTS[k])));
        end
        send_item(f, v);
    endtask

    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_result(converted);
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("lens_fov_table_interpolator_tb: errors");
            $finish;
        end
    end

    initial
    begin
        logic [VAL_W-1:0] lens_dir [$];
        logic [VAL_W-1:0] fov_dir [$];
        int idle_set [4];
        int stall_set [4];
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        func = FUNC_LENS_TO_FOV;
        value = '0;
        result_ready = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        quiet_cycles = 0;
        sent = 0;
        idle_set = '{0, 79, 0, 33};
        stall_set = '{0, 0, 79, 33};
        lens_dir = '{0, 10093, 10094, 10095, 11040, 50000, 102399999, 102400000,
                     102400001, 27'h7FFFFFF};
        fov_dir = '{0, 1637, 1638, 1639, 65536, 1000000, 10485760, 11468800,
                    11468801, 27'h7FFFFFF};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (lens_dir[i])
            send_item(FUNC_LENS_TO_FOV, lens_dir[i]);
        foreach (fov_dir[i])
            send_item(FUNC_FOV_TO_LENS, fov_dir[i]);
        for (int p = 0; p < 4; p++)
        begin
            idle_pct = idle_set[p];
            stall_pct = stall_set[p];
            repeat (RANDOM_PER_PHASE)
                send_random_item();
        end
        item_valid <= 1'b0;
        stall_pct = 0;
        while (sb.pending_conversions.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("covered %0d conversions in both directions, clamped ends and breakpoints,",
                 sent);
        $display("under four sender idle / receiver stall mixes; %0d results checked",
                 sb.checked);
        if (sb.mismatches == 0 && sb.pending_conversions.size() == 0)
            $display("lens_fov_table_interpolator_tb: clean");
        else
            $display("lens_fov_table_interpolator_tb: errors");
        $finish;
    end
endmodule

[lens_fov_table_interpolator.f]
rtl/core/lfti_pkg.sv
rtl/core/lfti_seg.sv
rtl/core/lfti_mul.sv
rtl/core/lfti_div.sv
rtl/core/lens_fov_table_interpolator.sv
verif/lens_fov_table_interpolator_tb.sv
